@@ hdl/pp_pkg.sv @@
// ----------------------------------------------------------------------------
// pp_pkg: shared definitions for the permutation parity block
// Field widths, default size limit, result codes and sequencer states.
// ----------------------------------------------------------------------------
package pp_pkg;

  // default limit on the number of elements in one permutation
  localparam int MAX_N_DEF = 64;

  // field widths
  localparam int ELEM_W = 8;
  localparam int SIGN_W = 2;
  localparam int DATA_W = 8;

  typedef logic [SIGN_W-1:0] sign_t;

  // result codes, two's complement
  localparam sign_t SIGN_BAD  = 2'b00;
  localparam sign_t SIGN_EVEN = 2'b01;
  localparam sign_t SIGN_ODD  = 2'b11;

  // sequencer states
  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_PRIME = 6'b000010,
    ST_CHK   = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_WALK  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

endpackage

@@ hdl/permutation_parity.sv @@
// ----------------------------------------------------------------------------
// permutation_parity: sign of a permutation streamed one element per word
// Stores the elements, checks them, then walks the cycles for parity.
// ----------------------------------------------------------------------------
// Input words carry one signed 8-bit element in in_tdata; in_tlast marks the
// final element, and the count of words received is the length n. After the
// last word one result word leaves on the out_ channel: 1 for an even
// permutation, -1 (2'b11) for odd, 0 when an element is out of range after
// wrapping, a value repeats, or more than MAX_N elements arrived.
// Elements load at one per cycle while in_tready is high. After the last
// word in_tready stays low during evaluation: a priming step, the wrap and
// duplicate check of each element, then the cycle walk (one scan step per
// index plus one step per visited element), and a final step to post the
// result. The single read port of the element store sets the pace of this
// evaluation. An invalid set found early ends evaluation at once.
// The result sits in an output register; loading of the next permutation
// starts while it waits, and only its evaluation end waits for out_tready.
// Synchronous reset (rst_n low) empties the block and drops out_tvalid.
// ----------------------------------------------------------------------------
module permutation_parity #(
  parameter int MAX_N = pp_pkg::MAX_N_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input words
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [pp_pkg::DATA_W-1:0] in_tdata,   // [7:0] element
  input  logic                      in_tlast,
  // result words
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [pp_pkg::DATA_W-1:0] out_tdata   // [1:0] sign, [7:2] zero
);

  localparam int IW = $clog2(MAX_N);
  localparam int CW = $clog2(MAX_N + 1);

  pp_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [MAX_N-1:0] seen_r, seen_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             par_r, par_nxt;
  logic             bad_r, bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  pp_pkg::sign_t    sign_r, sign_nxt;

  logic                      mem_wr_en;
  logic [IW-1:0]             mem_wr_addr;
  logic [pp_pkg::ELEM_W-1:0] mem_wr_data;
  logic [IW-1:0]             mem_rd_addr;
  logic [pp_pkg::ELEM_W-1:0] mem_rd_data;

  logic          wrap_ok;
  logic [CW-1:0] wrap_idx;
  logic [CW-1:0] idx_inc;
  logic [IW-1:0] walk_nxt;
  logic          in_acc;
  logic          is_full;

  // element store
  pp_mem #(
    .DEPTH (MAX_N),
    .AW    (IW),
    .DW    (pp_pkg::ELEM_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // wrap and range check of the word just read
  pp_wrap #(
    .CW (CW)
  ) u_wrap (
    .elem     (mem_rd_data),
    .n        (cnt_r),
    .in_range (wrap_ok),
    .idx      (wrap_idx)
  );

  assign in_acc   = in_tvalid && in_tready;
  assign is_full  = (cnt_r == CW'(MAX_N));
  assign idx_inc  = CW'(idx_r + 1'b1);
  assign walk_nxt = mem_rd_data[IW-1:0];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    seen_nxt      = seen_r;
    idx_nxt       = idx_r;
    par_nxt       = par_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_tready;
    sign_nxt      = sign_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = cnt_r[IW-1:0];
    mem_wr_data   = in_tdata[pp_pkg::ELEM_W-1:0];
    mem_rd_addr   = idx_r[IW-1:0];
    in_tready     = 1'b0;

    unique case (state_r)
      pp_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        if (in_acc) begin
          if (is_full) begin
            ovf_nxt = 1'b1;
          end else begin
            mem_wr_en = 1'b1;
            cnt_nxt   = CW'(cnt_r + 1'b1);
          end
          if (in_tlast) begin
            if (ovf_r || is_full) begin
              bad_nxt   = 1'b1;
              state_nxt = pp_pkg::ST_FIN;
            end else begin
              state_nxt = pp_pkg::ST_PRIME;
            end
          end
        end
      end

      // fetch the first element
      pp_pkg::ST_PRIME: begin
        mem_rd_addr = '0;
        idx_nxt     = '0;
        state_nxt   = pp_pkg::ST_CHK;
      end

      // wrap, range and duplicate check, write back the wrapped value
      pp_pkg::ST_CHK: begin
        if (!wrap_ok || seen_r[wrap_idx[IW-1:0]]) begin
          bad_nxt   = 1'b1;
          state_nxt = pp_pkg::ST_FIN;
        end else begin
          seen_nxt[wrap_idx[IW-1:0]] = 1'b1;
          mem_wr_en   = 1'b1;
          mem_wr_addr = idx_r[IW-1:0];
          mem_wr_data = pp_pkg::ELEM_W'(wrap_idx);
          mem_rd_addr = idx_inc[IW-1:0];
          if (idx_inc == cnt_r) begin
            seen_nxt  = '0;
            idx_nxt   = '0;
            par_nxt   = 1'b0;
            state_nxt = pp_pkg::ST_SCAN;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end

      // look for the start of the next unvisited cycle
      pp_pkg::ST_SCAN: begin
        if (idx_r == cnt_r) begin
          state_nxt = pp_pkg::ST_FIN;
        end else if (seen_r[idx_r[IW-1:0]]) begin
          idx_nxt = idx_inc;
        end else begin
          seen_nxt[idx_r[IW-1:0]] = 1'b1;
          mem_rd_addr = idx_r[IW-1:0];
          par_nxt     = !par_r;
          state_nxt   = pp_pkg::ST_WALK;
        end
      end

      // follow the cycle until it closes
      pp_pkg::ST_WALK: begin
        if (seen_r[walk_nxt]) begin
          idx_nxt   = idx_inc;
          state_nxt = pp_pkg::ST_SCAN;
        end else begin
          seen_nxt[walk_nxt] = 1'b1;
          mem_rd_addr = walk_nxt;
        end
      end

      // post the result once the output register is free
      pp_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (bad_r) begin
            sign_nxt = pp_pkg::SIGN_BAD;
          end else if (cnt_r[0] ^ par_r) begin
            sign_nxt = pp_pkg::SIGN_ODD;
          end else begin
            sign_nxt = pp_pkg::SIGN_EVEN;
          end
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          seen_nxt  = '0;
          bad_nxt   = 1'b0;
          par_nxt   = 1'b0;
          state_nxt = pp_pkg::ST_LOAD;
        end
      end

      default: begin
        state_nxt = pp_pkg::ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pp_pkg::ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      seen_r      <= '0;
      idx_r       <= '0;
      par_r       <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      seen_r      <= seen_nxt;
      idx_r       <= idx_nxt;
      par_r       <= par_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    sign_r <= sign_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pp_pkg::DATA_W'(sign_r);

endmodule

@@ hdl/pp_mem.sv @@
// ----------------------------------------------------------------------------
// pp_mem: element store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module pp_mem #(
  parameter int DEPTH = pp_pkg::MAX_N_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = pp_pkg::ELEM_W
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/pp_wrap.sv @@
// ----------------------------------------------------------------------------
// pp_wrap: element wrap and range check
// Adds n to a negative element and checks the result lies in 0..n-1.
// ----------------------------------------------------------------------------
module pp_wrap #(
  parameter int CW = 7
) (
  input  logic [pp_pkg::ELEM_W-1:0] elem,
  input  logic [CW-1:0]             n,
  output logic                      in_range,
  output logic [CW-1:0]             idx
);

  localparam int SW = ((CW > pp_pkg::ELEM_W) ? CW : pp_pkg::ELEM_W) + 2;

  logic [SW-1:0] k_ext;
  logic [SW-1:0] n_ext;
  logic [SW-1:0] kw;

  // sign-extend the element, zero-extend the length
  assign k_ext = {{(SW-pp_pkg::ELEM_W){elem[pp_pkg::ELEM_W-1]}}, elem};
  assign n_ext = {{(SW-CW){1'b0}}, n};

  // negative counts from the end
  assign kw = elem[pp_pkg::ELEM_W-1] ? (k_ext + n_ext) : k_ext;

  // nonnegative and below n
  assign in_range = !kw[SW-1] && (kw < n_ext);
  assign idx      = kw[CW-1:0];

endmodule

@@ hdl/pp_checker.sv @@
// ----------------------------------------------------------------------------
// pp_checker: port-level checks for the permutation parity block
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      in_tlast,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [pp_pkg::DATA_W-1:0] out_tdata
);

  // result word carries only a sign, upper bits zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[pp_pkg::DATA_W-1:pp_pkg::SIGN_W] == '0))
    else $error("result word has nonzero padding");

  // sign code is one of the three legal values
  a_sign_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[pp_pkg::SIGN_W-1:0] == pp_pkg::SIGN_BAD ||
                    out_tdata[pp_pkg::SIGN_W-1:0] == pp_pkg::SIGN_EVEN ||
                    out_tdata[pp_pkg::SIGN_W-1:0] == pp_pkg::SIGN_ODD))
    else $error("illegal sign code");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");

  // the block evaluates after the last word before taking more input
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after last word");

endmodule

bind permutation_parity pp_checker u_pp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ verif/permutation_parity_tb.sv @@
// ----------------------------------------------------------------------------
// permutation_parity_tb: self-checking bench for the permutation parity block
// Streams candidate permutations word by word and predicts each sign in a
// scoreboard: directed corner cases first, then random valid, repeated,
// out-of-range, noisy and oversized sets, with random gaps on both channels.
// ----------------------------------------------------------------------------
module permutation_parity_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_N      = pp_pkg::MAX_N_DEF;
  localparam int WORD_GOAL  = 2000;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_CYC  = 3 * MAX_N + 16;
  localparam int HOLD_CYC   = 400;

  // kinds of random permutation sets
  typedef enum int {
    SET_GOOD,
    SET_DUP,
    SET_RANGE,
    SET_NOISE,
    SET_LONG
  } set_kind_t;

  // --------------------------------------------------------------------------
  // scoreboard: element store, sign prediction and result check
  // --------------------------------------------------------------------------
  class parity_board;
    byte           held[pp_pkg::MAX_N_DEF];
    int            held_cnt;
    bit            overflow;
    pp_pkg::sign_t sign_fifo[$];
    int            errors;

    function new();
      held_cnt = 0;
      overflow = 0;
      errors   = 0;
    endfunction

    // sign of the held set: wrap, range and repeat check, then cycle count
    function pp_pkg::sign_t predict_sign();
      bit used[pp_pkg::MAX_N_DEF];
      bit visited[pp_pkg::MAX_N_DEF];
      int wrapped[pp_pkg::MAX_N_DEF];
      int n, k, c, cycles;
      n = held_cnt;
      if (overflow || n == 0) return pp_pkg::SIGN_BAD;
      foreach (used[i]) begin
        used[i]    = 1'b0;
        visited[i] = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
        k = held[i];
        if (k < 0) k += n;
        if (k < 0 || k >= n) return pp_pkg::SIGN_BAD;
        if (used[k]) return pp_pkg::SIGN_BAD;
        used[k]    = 1'b1;
        wrapped[i] = k;
      end
      cycles = 0;
      for (int i = 0; i < n; i++) begin
        if (!visited[i]) begin
          cycles++;
          c = i;
          while (!visited[c]) begin
            visited[c] = 1'b1;
            c = wrapped[c];
          end
        end
      end
      return ((n - cycles) % 2 != 0) ? pp_pkg::SIGN_ODD : pp_pkg::SIGN_EVEN;
    endfunction

    // accepted input word
    function void note_element(logic [pp_pkg::DATA_W-1:0] data, logic last);
      if (held_cnt < pp_pkg::MAX_N_DEF) begin
        held[held_cnt] = byte'(data[pp_pkg::ELEM_W-1:0]);
        held_cnt++;
      end else begin
        overflow = 1'b1;
      end
      if (last) begin
        sign_fifo.push_back(predict_sign());
        held_cnt = 0;
        overflow = 1'b0;
      end
    endfunction

    // accepted result word against the oldest expected sign
    function void check_word(logic [pp_pkg::DATA_W-1:0] data);
      logic [pp_pkg::DATA_W-1:0] want;
      if (sign_fifo.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result %h with no sign expected", data);
        return;
      end
      want = {{(pp_pkg::DATA_W-pp_pkg::SIGN_W){1'b0}}, sign_fifo.pop_front()};
      if (data !== want) begin
        errors++;
        if (errors <= 10) $display("sign mismatch: expected %h, got %h", want, data);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [pp_pkg::DATA_W-1:0] in_tdata = '0;
  logic                      in_tlast = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [pp_pkg::DATA_W-1:0] out_tdata;

  parity_board board = new();
  int          words_sent = 0;
  int          cycle_cnt = 0;
  bit          tx_burst = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  permutation_parity u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // monitor both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_word(out_tdata);
      if (in_tvalid && in_tready) board.note_element(in_tdata, in_tlast);
    end
  end

  // --------------------------------------------------------------------------
  // result receiver: random stalls, bursts, two long hold-offs
  // --------------------------------------------------------------------------
  initial begin
    int  d;
    int  got;
    bit  rx_burst;
    got = 0;
    rx_burst = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (got % 16 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (got == 40 || got == 200) d = HOLD_CYC;
      else if (rx_burst) d = 0;
      else d = $urandom_range(0, 3);
      if (d > 0) begin
        out_tready <= 1'b0;
        repeat (d) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      got++;
    end
  end

  // --------------------------------------------------------------------------
  // sender tasks
  // --------------------------------------------------------------------------
  task automatic send_seq(byte seq[$]);
    int d;
    foreach (seq[i]) begin
      d = tx_burst ? 0 : $urandom_range(0, 3);
      if (d > 0) begin
        in_tvalid <= 1'b0;
        repeat (d) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= seq[i];
      in_tlast  <= (i == seq.size() - 1);
      do @(posedge clk); while (!in_tready);
      words_sent++;
    end
    // block is busy after the last word, so dropping in_tvalid here costs nothing
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // build a random set of the given kind and length
  task automatic send_random(set_kind_t kind, int n);
    byte seq[$];
    int  j, a, b;
    byte tmp;
    seq = {};
    for (int i = 0; i < n; i++) seq.push_back(byte'(i));
    // shuffle, then for sets of at most MAX_N write some entries counted from the end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = seq[i];
      seq[i] = seq[j];
      seq[j] = tmp;
    end
    if (n <= MAX_N) begin
      foreach (seq[i]) if ($urandom_range(0, 1)) seq[i] = byte'(seq[i] - n);
    end
    case (kind)
      SET_DUP: begin
        if (n >= 2) begin
          a = $urandom_range(0, n - 1);
          b = (a + $urandom_range(1, n - 1)) % n;
          seq[b] = seq[a];
        end
      end
      SET_RANGE: begin
        a = $urandom_range(0, n - 1);
        if ($urandom_range(0, 1)) seq[a] = byte'($urandom_range(n, 127));
        else seq[a] = byte'(-$urandom_range(n + 1, 128));
      end
      SET_NOISE: begin
        foreach (seq[i]) seq[i] = byte'($urandom_range(0, 255));
      end
      default: ;
    endcase
    send_seq(seq);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    byte       seq[$];
    int        perm_cnt;
    int        pick;
    int        n;
    set_kind_t kind;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single elements: zero and minus one are even, others invalid
    send_seq('{0});
    send_seq('{-1});
    send_seq('{1});
    send_seq('{127});
    send_seq('{-128});
    // pairs and triples, plain and counted from the end
    send_seq('{0, 1});
    send_seq('{1, 0});
    send_seq('{-1, -2});
    send_seq('{-2, -1});
    send_seq('{0, 0});
    send_seq('{-3, 0});
    send_seq('{2, 0, 1});
    send_seq('{0, 2, 1});
    send_seq('{-128, 127, 0});
    // full size, reversed
    seq = {};
    for (int i = 0; i < MAX_N; i++) seq.push_back(byte'(MAX_N - 1 - i));
    send_seq(seq);
    // one element too many
    seq = {};
    for (int i = 0; i <= MAX_N; i++) seq.push_back(byte'(i));
    send_seq(seq);

    // random sets, mostly short and well formed
    perm_cnt = 0;
    while (words_sent < WORD_GOAL) begin
      if (perm_cnt % 64 == 63) begin
        while (board.sign_fifo.size() != 0) @(posedge clk);
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) kind = SET_GOOD;
      else if (pick < 80) kind = SET_DUP;
      else if (pick < 90) kind = SET_RANGE;
      else if (pick < 97) kind = SET_NOISE;
      else kind = SET_LONG;
      if (kind == SET_LONG) n = $urandom_range(MAX_N + 1, MAX_N + 6);
      else if ($urandom_range(0, 7) == 0) n = $urandom_range(11, MAX_N);
      else n = $urandom_range(1, 10);
      send_random(kind, n);
      perm_cnt++;
    end

    // drain
    while (board.sign_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (board.errors == 0 && board.sign_fifo.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
